[rtl/core/wmct_pkg.sv]
// ----------------------------------------------------------------------------
// wmct_pkg
// shared types and constants of the 3x3 window contrast threshold block
// ----------------------------------------------------------------------------
package wmct_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // one line store entry: the same column of the two previous rows
    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
    } line_word_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int DIM_W       = 12;
    localparam int OUT_COL_W   = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [7:0]       THRESHOLD_RESET = 8'd180;
    localparam logic [DIM_W-1:0] WIDTH_RESET     = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET    = 12'd480;
    localparam logic [DIM_W-1:0] MIN_DIM         = 12'd3;

endpackage

[rtl/core/window_max_contrast_threshold.sv]
// ----------------------------------------------------------------------------
// window_max_contrast_threshold
// 3x3 local max absolute difference, thresholded, on a raster rgb stream
// ----------------------------------------------------------------------------
// usage
//   input channel: one rgb pixel per transaction in raster order, with
//   start_of_frame marking column 0 of row 0; in_valid / in_ready
//   output channel: one transaction per center pixel one row and one column
//   behind the input, giving its position and the per-channel contrast;
//   pixels in row 0 or column 0 of a frame give no transaction
//   config port: cfg_wr_en writes cfg_data into threshold (0), frame_width
//   (1) or frame_height (2); other indexes are ignored
// throughput: one pixel per cycle while in_ready holds, set by the single read
//   and single write port of the line store, which is read at the pixel's column on
//   accept and written back when the pixel leaves stage 1
// path: a result passes the line store read stage and the window into the output
//   register once the pixel that completes its window is accepted
// stall: three pipeline slots (line store read, window, output register)
//   keep accepting while a result waits; in_ready drops only when all three
//   hold work
// reset: counters, window, valid flags and configuration registers return to
//   defaults at once; the line store needs no clearing pass since unwritten
//   entries only feed border centers, which report zero
// ----------------------------------------------------------------------------
module window_max_contrast_threshold
    import wmct_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   start_of_frame,
    input  logic [7:0]             red_in,
    input  logic [7:0]             green_in,
    input  logic [7:0]             blue_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_COL_W-1:0]   center_col,
    output logic [DIM_W-1:0]       center_row,
    output logic [7:0]             red_contrast,
    output logic [7:0]             green_contrast,
    output logic [7:0]             blue_contrast,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // column counter width, and a width able to hold the effective row width
    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > DIM_W) ? WW : DIM_W;

    // configuration registers
    logic [7:0]       thr_reg;
    logic [DIM_W-1:0] fw_reg;
    logic [DIM_W-1:0] fh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
            fw_reg  <= WIDTH_RESET;
            fh_reg  <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:    thr_reg <= cfg_data[7:0];
                CFG_FRAME_WIDTH:  fw_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: fh_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // effective frame size, clamped
    logic [EW-1:0]    eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [EW-1:0]    fw_ext;

    always_comb
    begin
        fw_ext = EW'(fw_reg);
        if (fw_reg < MIN_DIM)
        begin
            eff_w = EW'(MIN_DIM);
        end
        else if (fw_ext > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = fw_ext;
        end
        eff_h = (fh_reg < MIN_DIM) ? MIN_DIM : fh_reg;
    end

    // pipeline handshake
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic in_fire;
    logic s1_adv;
    logic s2_adv;

    assign s2_adv   = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // position of the incoming pixel, normalized against the current size
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] row_next;
    logic [EW-1:0]    c_in;
    logic [DIM_W-1:0] r_in;
    logic [EW-1:0]    c_cur;
    logic [DIM_W-1:0] r_cur;
    logic [EW-1:0]    c_inc;
    logic [DIM_W-1:0] r_inc;
    logic [EW-1:0]    c_m1;

    always_comb
    begin
        c_in = start_of_frame ? '0 : EW'(col_reg);
        r_in = start_of_frame ? '0 : row_reg;
        if (c_in >= eff_w)
        begin
            c_cur = '0;
            r_cur = r_in + 1'b1;
        end
        else
        begin
            c_cur = c_in;
            r_cur = r_in;
        end
        if (r_cur >= eff_h)
        begin
            r_cur = '0;
        end

        // position of the following pixel
        c_inc = c_cur + 1'b1;
        if (c_inc >= eff_w)
        begin
            col_next = '0;
            r_inc    = r_cur + 1'b1;
        end
        else
        begin
            col_next = c_inc[CW-1:0];
            r_inc    = r_cur;
        end
        row_next = (r_inc >= eff_h) ? '0 : r_inc;
        c_m1     = c_cur - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: line store read in flight
    logic [CW-1:0]        s1_col_reg;
    pixel_t               s1_pix_reg;
    logic                 s1_res_reg;
    logic                 s1_zero_reg;
    logic [OUT_COL_W-1:0] s1_ocol_reg;
    logic [DIM_W-1:0]     s1_orow_reg;
    pixel_t               pix_in;

    assign pix_in = '{red: red_in, green: green_in, blue: blue_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg  <= c_cur[CW-1:0];
            s1_pix_reg  <= pix_in;
            // a result only for input pixels past the first row and column
            s1_res_reg  <= (r_cur != '0) && (c_cur != '0);
            // centers on the frame border report zero
            s1_zero_reg <= (r_cur == DIM_W'(1)) || (c_cur == EW'(1));
            s1_ocol_reg <= c_m1[OUT_COL_W-1:0];
            s1_orow_reg <= r_cur - 1'b1;
        end
    end

    // line store: upper row is two rows back, lower row one row back
    line_word_t ls_rd;
    line_word_t ls_wr;

    assign ls_wr = '{upper: ls_rd.lower, lower: s1_pix_reg};

    wmct_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CW)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (c_cur[CW-1:0]),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (ls_wr),
        .rd_data (ls_rd)
    );

    // stage 2: window holds the neighbourhood of the pending center
    pixel_t               contrast;
    logic                 s2_zero_reg;
    logic [OUT_COL_W-1:0] s2_ocol_reg;
    logic [DIM_W-1:0]     s2_orow_reg;

    wmct_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (s1_adv),
        .col_top   (ls_rd.upper),
        .col_mid   (ls_rd.lower),
        .col_bot   (s1_pix_reg),
        .threshold (thr_reg),
        .contrast  (contrast)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_res_reg;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_zero_reg <= s1_zero_reg;
            s2_ocol_reg <= s1_ocol_reg;
            s2_orow_reg <= s1_orow_reg;
        end
    end

    // output register
    pixel_t               out_con_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic [DIM_W-1:0]     out_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_con_reg <= s2_zero_reg ? '0 : contrast;
            out_col_reg <= s2_ocol_reg;
            out_row_reg <= s2_orow_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign center_col     = out_col_reg;
    assign center_row     = out_row_reg;
    assign red_contrast   = out_con_reg.red;
    assign green_contrast = out_con_reg.green;
    assign blue_contrast  = out_con_reg.blue;

    // position after an accepted pixel lies inside the frame in use then
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (EW'(col_reg) < $past(eff_w)) && (row_reg < $past(eff_h)))
        else $error("position counter left the frame");

    // input stalls only when every pipeline slot is occupied and blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s2_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with a free pipeline slot");

    // centers in the first row are frame border and report zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (center_row == '0)) |->
        (red_contrast == '0) && (green_contrast == '0) && (blue_contrast == '0))
        else $error("border center reported contrast");

endmodule

[rtl/core/wmct_line_store.sv]
// ----------------------------------------------------------------------------
// wmct_line_store
// two-row line store in one synchronous memory, with write-to-read forwarding
// ----------------------------------------------------------------------------
module wmct_line_store
    import wmct_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  line_word_t        wr_data,
    output line_word_t        rd_data
);

    line_word_t mem [DEPTH];
    line_word_t rd_q_reg;
    line_word_t fwd_data_reg;
    logic       fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // same entry written and read at one edge: hand over the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;

endmodule

[rtl/core/wmct_window.sv]
// ----------------------------------------------------------------------------
// wmct_window
// 3x3 pixel window and per-channel max neighbour difference with threshold
// ----------------------------------------------------------------------------
module wmct_window
    import wmct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  pixel_t     col_top,
    input  pixel_t     col_mid,
    input  pixel_t     col_bot,
    input  logic [7:0] threshold,
    output pixel_t     contrast
);

    pixel_t win_reg [3][3];

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [7:0] channel_contrast(
        input logic [7:0]  ctr,
        input logic [63:0] nb,
        input logic [7:0]  thr
    );
        logic [7:0] d [8];
        logic [7:0] m0;
        logic [7:0] m1;
        logic [7:0] m2;
        logic [7:0] m3;
        logic [7:0] best;
        for (int k = 0; k < 8; k++)
        begin
            d[k] = abs_diff(ctr, nb[8*k +: 8]);
        end
        m0   = max2(d[0], d[1]);
        m1   = max2(d[2], d[3]);
        m2   = max2(d[4], d[5]);
        m3   = max2(d[6], d[7]);
        best = max2(max2(m0, m1), max2(m2, m3));
        return (best > thr) ? best : 8'd0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (shift_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= col_top;
            win_reg[1][2] <= col_mid;
            win_reg[2][2] <= col_bot;
        end
    end

    logic [63:0] red_nb;
    logic [63:0] green_nb;
    logic [63:0] blue_nb;

    assign red_nb   = {win_reg[0][0].red,   win_reg[0][1].red,   win_reg[0][2].red,
                       win_reg[1][0].red,   win_reg[1][2].red,
                       win_reg[2][0].red,   win_reg[2][1].red,   win_reg[2][2].red};
    assign green_nb = {win_reg[0][0].green, win_reg[0][1].green, win_reg[0][2].green,
                       win_reg[1][0].green, win_reg[1][2].green,
                       win_reg[2][0].green, win_reg[2][1].green, win_reg[2][2].green};
    assign blue_nb  = {win_reg[0][0].blue,  win_reg[0][1].blue,  win_reg[0][2].blue,
                       win_reg[1][0].blue,  win_reg[1][2].blue,
                       win_reg[2][0].blue,  win_reg[2][1].blue,  win_reg[2][2].blue};

    assign contrast.red   = channel_contrast(win_reg[1][1].red,   red_nb,   threshold);
    assign contrast.green = channel_contrast(win_reg[1][1].green, green_nb, threshold);
    assign contrast.blue  = channel_contrast(win_reg[1][1].blue,  blue_nb,  threshold);

endmodule
